@@ hw/rtl/ddo_pkg.sv @@
// Shared types and constants for the differential-drive odometry block.
// Holds the sequencer state type, divider job codes and the fixed-point constants.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ddo_pkg;

  // Beat widths on the stream ports.
  localparam int IN_W  = 48;
  localparam int OUT_W = 224;

  // CORDIC iteration count and the width of its counter.
  localparam int CORDIC_STAGES = 24;
  localparam int CNT_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TICK_SCALE   = 2'd0;
  localparam logic [1:0] CFG_WHEEL_RADIUS = 2'd1;
  localparam logic [1:0] CFG_WHEEL_SEP    = 2'd2;

  // Register reset values.
  localparam logic [31:0] RST_TICK_SCALE   = 32'd6588397;
  localparam logic [15:0] RST_WHEEL_RADIUS = 16'd2163;
  localparam logic [15:0] RST_WHEEL_SEP    = 16'd10486;

  // Turns per radian scaled by 2^64, and the CORDIC start gain in Q2.30.
  localparam logic [63:0] TURN_PER_RAD = 64'h28BE60DB9391054A;
  localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;

  // Arctangent of 2^-i as a binary angle.
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
    ST_DVL, ST_DIV, ST_DVS,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4,
    ST_CSET, ST_CRD,
    ST_P0, ST_P1, ST_P2,
    ST_FIN
  } state_t;

  // Jobs for the shared divider.
  typedef enum logic [2:0] {
    DV_RAD,
    DV_ANG,
    DV_LIN,
    DV_LFT,
    DV_RGT
  } div_sel_t;

endpackage

@@ hw/rtl/diff_drive_odometry.sv @@
// Top level of the differential-drive wheel odometry block.
// One sequencer drives a shared 32x32 multiplier, a radix-2 divider and a CORDIC unit.
// Depends on ddo_pkg.
`timescale 1ns / 1ps

//  channel   direction  beat contents (lowest bits first)
//  s_*       in         left_ticks, right_ticks, interval
//  m_*       out        pos_x, pos_y, heading_angle, lin_vel, ang_vel,
//                       left_wheel_rate, right_wheel_rate
//  cfg_*     in         register index and write data, no handshake
//
// An item with a nonzero interval runs from accept until its result is loaded
// through five 64-step divisions on the shared divider, which set most of the time,
// with the CORDIC loop and thirteen multiplier passes making up the rest.
// An item with a zero interval is taken at once and leaves no result.
// rst is synchronous; it restores the registers, clears the pose and drops m_tvalid.
// A held result does not block the next item; only a second finished result waits.

module diff_drive_odometry (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // left_ticks[15:0], right_ticks[31:16], interval[47:32]
  input  logic [ddo_pkg::IN_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // pos_x, pos_y, heading_angle, lin_vel, ang_vel, left_wheel_rate,
  // right_wheel_rate, 32 bits each from bit 0 up
  output logic [ddo_pkg::OUT_W-1:0] m_tdata,
  input  logic                     cfg_wr_en,
  input  logic [1:0]               cfg_index,
  input  logic [31:0]              cfg_data
);

  ddo_pkg::state_t   state, state_next;
  ddo_pkg::div_sel_t div_sel;

  // Configuration.
  logic [31:0] tick_scale;
  logic [15:0] radius;
  logic [15:0] wheel_sep;

  // Pose.
  logic [31:0] pose_x, pose_y, pose_heading;

  // Latched item.
  logic [16:0] lt_mag, rt_mag, sum_mag, diff_mag;
  logic        lt_neg, rt_neg, sum_neg, diff_neg;
  logic [15:0] dt;

  // Products and intermediate values.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [47:0] sr, lw, rw;
  logic [63:0] p1, p2, rad;
  logic [96:0] acc;
  logic [31:0] dh;

  // Divider.
  logic [63:0] div_q;
  logic [15:0] div_rem, div_den;
  logic [5:0]  div_cnt;
  logic [16:0] rem_sh;
  logic        rem_ge;

  // CORDIC.
  logic signed [33:0] cx, cy, cz;
  logic signed [33:0] sx, sy;
  logic               flip;
  logic [ddo_pkg::CNT_W-1:0] ci;

  // Rates.
  logic [31:0] lin_r, ang_r, lft_r, rgt_r;

  // Input fields.
  logic signed [15:0] in_lt, in_rt;
  logic [15:0]        in_dt;
  logic signed [16:0] in_sum, in_diff;
  logic               take;
  logic               out_go;

  // Values derived from registers.
  logic [30:0] ds_mag;
  logic [15:0] sep_eff;
  logic [32:0] hi;
  logic [31:0] half, mid, ang;
  logic [33:0] xmag, ymag;
  logic        x_neg, y_neg;

  assign in_lt   = $signed(s_tdata[15:0]);
  assign in_rt   = $signed(s_tdata[31:16]);
  assign in_dt   = s_tdata[47:32];
  assign in_sum  = 17'(in_lt) + 17'(in_rt);
  assign in_diff = 17'(in_rt) - 17'(in_lt);
  assign take    = s_tvalid && s_tready;
  assign out_go  = !m_tvalid || m_tready;

  assign ds_mag  = p1[63:33];
  assign sep_eff = (wheel_sep == 16'd0) ? 16'd1 : wheel_sep;
  assign hi      = acc[96:64];
  assign half    = diff_neg ? (32'd0 - hi[32:1]) : hi[32:1];
  assign mid     = pose_heading + half;
  assign ang     = (mid[31:30] == 2'b01 || mid[31:30] == 2'b10) ?
                   (mid ^ 32'h8000_0000) : mid;
  assign xmag    = cx[33] ? 34'(-cx) : 34'(cx);
  assign ymag    = cy[33] ? 34'(-cy) : 34'(cy);
  assign x_neg   = sum_neg ^ flip ^ cx[33];
  assign y_neg   = sum_neg ^ flip ^ cy[33];

  assign rem_sh  = {div_rem, div_q[63]};
  assign rem_ge  = rem_sh >= {1'b0, div_den};

  // Shift right with rounding toward zero.
  function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
                                                input logic [ddo_pkg::CNT_W-1:0] s);
    logic [33:0] m;
    m = v[33] ? 34'(-v) : 34'(v);
    m = m >> s;
    return v[33] ? -$signed(m) : $signed(m);
  endfunction

  // Position increment: magnitude product over 2^30 with the sign put back.
  function automatic logic [31:0] pos_inc(input logic neg, input logic [63:0] p);
    logic [33:0] m;
    m = p[63:30];
    return neg ? 32'(34'd0 - m) : m[31:0];
  endfunction

  // Clamp a signed magnitude to the 32-bit range.
  function automatic logic [31:0] sat_rate(input logic neg, input logic [63:0] m);
    if (neg) begin
      return (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - m);
    end
    return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  assign sx = shr_tz(cx, ci);
  assign sy = shr_tz(cy, ci);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ddo_pkg::ST_IDLE: if (take && in_dt != 16'd0) state_next = ddo_pkg::ST_M0;
      ddo_pkg::ST_M0:   state_next = ddo_pkg::ST_M1;
      ddo_pkg::ST_M1:   state_next = ddo_pkg::ST_M2;
      ddo_pkg::ST_M2:   state_next = ddo_pkg::ST_M3;
      ddo_pkg::ST_M3:   state_next = ddo_pkg::ST_M4;
      ddo_pkg::ST_M4:   state_next = ddo_pkg::ST_M5;
      ddo_pkg::ST_M5:   state_next = ddo_pkg::ST_M6;
      ddo_pkg::ST_M6:   state_next = ddo_pkg::ST_M7;
      ddo_pkg::ST_M7:   state_next = ddo_pkg::ST_DVL;
      ddo_pkg::ST_DVL:  state_next = ddo_pkg::ST_DIV;
      ddo_pkg::ST_DIV:  if (div_cnt == 6'd63) state_next = ddo_pkg::ST_DVS;
      ddo_pkg::ST_DVS: begin
        case (div_sel)
          ddo_pkg::DV_RAD: state_next = ddo_pkg::ST_H0;
          ddo_pkg::DV_RGT: state_next = ddo_pkg::ST_FIN;
          default:         state_next = ddo_pkg::ST_DVL;
        endcase
      end
      ddo_pkg::ST_H0:   state_next = ddo_pkg::ST_H1;
      ddo_pkg::ST_H1:   state_next = ddo_pkg::ST_H2;
      ddo_pkg::ST_H2:   state_next = ddo_pkg::ST_H3;
      ddo_pkg::ST_H3:   state_next = ddo_pkg::ST_H4;
      ddo_pkg::ST_H4:   state_next = ddo_pkg::ST_CSET;
      ddo_pkg::ST_CSET: state_next = ddo_pkg::ST_CRD;
      ddo_pkg::ST_CRD: begin
        if (ci == ddo_pkg::CNT_W'(ddo_pkg::CORDIC_STAGES - 1)) state_next = ddo_pkg::ST_P0;
      end
      ddo_pkg::ST_P0:   state_next = ddo_pkg::ST_P1;
      ddo_pkg::ST_P1:   state_next = ddo_pkg::ST_P2;
      ddo_pkg::ST_P2:   state_next = ddo_pkg::ST_DVL;
      ddo_pkg::ST_FIN:  if (out_go) state_next = ddo_pkg::ST_IDLE;
      default:          state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: input ready and multiplier operands.
  always_comb begin
    s_tready = (state == ddo_pkg::ST_IDLE);
    mul_a    = 32'd0;
    mul_b    = 32'd0;
    case (state)
      ddo_pkg::ST_M0: begin mul_a = tick_scale;          mul_b = {16'd0, radius}; end
      ddo_pkg::ST_M1: begin mul_a = {15'd0, lt_mag};     mul_b = tick_scale; end
      ddo_pkg::ST_M2: begin mul_a = {15'd0, rt_mag};     mul_b = tick_scale; end
      ddo_pkg::ST_M3: begin mul_a = {15'd0, sum_mag};    mul_b = sr[31:0]; end
      ddo_pkg::ST_M4: begin mul_a = {15'd0, sum_mag};    mul_b = {16'd0, sr[47:32]}; end
      ddo_pkg::ST_M5: begin mul_a = {15'd0, diff_mag};   mul_b = sr[31:0]; end
      ddo_pkg::ST_M6: begin mul_a = {15'd0, diff_mag};   mul_b = {16'd0, sr[47:32]}; end
      ddo_pkg::ST_H0: begin mul_a = rad[31:0];  mul_b = ddo_pkg::TURN_PER_RAD[31:0]; end
      ddo_pkg::ST_H1: begin mul_a = rad[31:0];  mul_b = ddo_pkg::TURN_PER_RAD[63:32]; end
      ddo_pkg::ST_H2: begin mul_a = rad[63:32]; mul_b = ddo_pkg::TURN_PER_RAD[31:0]; end
      ddo_pkg::ST_H3: begin mul_a = rad[63:32]; mul_b = ddo_pkg::TURN_PER_RAD[63:32]; end
      ddo_pkg::ST_P0: begin mul_a = {1'b0, ds_mag}; mul_b = xmag[31:0]; end
      ddo_pkg::ST_P1: begin mul_a = {1'b0, ds_mag}; mul_b = ymag[31:0]; end
      default: begin end
    endcase
  end

  // Control registers, configuration and pose.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ddo_pkg::ST_IDLE;
      div_sel      <= ddo_pkg::DV_RAD;
      m_tvalid     <= 1'b0;
      tick_scale   <= ddo_pkg::RST_TICK_SCALE;
      radius       <= ddo_pkg::RST_WHEEL_RADIUS;
      wheel_sep    <= ddo_pkg::RST_WHEEL_SEP;
      pose_x       <= 32'd0;
      pose_y       <= 32'd0;
      pose_heading <= 32'd0;
      div_cnt      <= 6'd0;
      ci           <= '0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        case (cfg_index)
          ddo_pkg::CFG_TICK_SCALE:   tick_scale   <= cfg_data;
          ddo_pkg::CFG_WHEEL_RADIUS: radius       <= cfg_data[15:0];
          ddo_pkg::CFG_WHEEL_SEP:    wheel_sep    <= cfg_data[15:0];
          default: begin end
        endcase
      end

      // Job order for the divider.
      if (state == ddo_pkg::ST_IDLE) div_sel <= ddo_pkg::DV_RAD;
      if (state == ddo_pkg::ST_P2)   div_sel <= ddo_pkg::DV_ANG;
      if (state == ddo_pkg::ST_DVS) begin
        case (div_sel)
          ddo_pkg::DV_ANG: div_sel <= ddo_pkg::DV_LIN;
          ddo_pkg::DV_LIN: div_sel <= ddo_pkg::DV_LFT;
          ddo_pkg::DV_LFT: div_sel <= ddo_pkg::DV_RGT;
          default:         div_sel <= div_sel;
        endcase
      end

      div_cnt <= (state == ddo_pkg::ST_DIV) ? div_cnt + 6'd1 : 6'd0;
      ci      <= (state == ddo_pkg::ST_CRD) ? ci + 1'b1 : '0;

      // Pose advance by the midpoint step.
      if (state == ddo_pkg::ST_P1) pose_x <= pose_x + pos_inc(x_neg, prod);
      if (state == ddo_pkg::ST_P2) begin
        pose_y       <= pose_y + pos_inc(y_neg, prod);
        pose_heading <= pose_heading + dh;
      end

      // Output register.
      if (state == ddo_pkg::ST_FIN && out_go) m_tvalid <= 1'b1;
      else if (m_tready)                      m_tvalid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    // Latch the item as magnitudes and signs.
    if (take) begin
      lt_neg   <= in_lt[15];
      rt_neg   <= in_rt[15];
      sum_neg  <= in_sum[16];
      diff_neg <= in_diff[16];
      lt_mag   <= in_lt[15]   ? 17'(-17'(in_lt)) : 17'(in_lt);
      rt_mag   <= in_rt[15]   ? 17'(-17'(in_rt)) : 17'(in_rt);
      sum_mag  <= in_sum[16]  ? 17'(-in_sum)     : 17'(in_sum);
      diff_mag <= in_diff[16] ? 17'(-in_diff)    : 17'(in_diff);
      dt       <= in_dt;
    end

    case (state)
      // Scale products and the two distance products.
      ddo_pkg::ST_M1: sr <= prod[47:0];
      ddo_pkg::ST_M2: lw <= prod[47:0];
      ddo_pkg::ST_M3: rw <= prod[47:0];
      ddo_pkg::ST_M4: p1 <= prod;
      ddo_pkg::ST_M5: p1 <= p1 + {prod[31:0], 32'd0};
      ddo_pkg::ST_M6: p2 <= prod;
      ddo_pkg::ST_M7: p2 <= p2 + {prod[31:0], 32'd0};

      // Divider load, steps and result store.
      ddo_pkg::ST_DVL: begin
        div_rem <= 16'd0;
        div_den <= (div_sel == ddo_pkg::DV_RAD) ? sep_eff : dt;
        case (div_sel)
          ddo_pkg::DV_RAD: div_q <= p2;
          ddo_pkg::DV_ANG: div_q <= rad;
          ddo_pkg::DV_LIN: div_q <= {33'd0, ds_mag};
          ddo_pkg::DV_LFT: div_q <= {16'd0, lw};
          default:         div_q <= {16'd0, rw};
        endcase
      end
      ddo_pkg::ST_DIV: begin
        div_rem <= rem_ge ? 16'(rem_sh - {1'b0, div_den}) : rem_sh[15:0];
        div_q   <= {div_q[62:0], rem_ge};
      end
      ddo_pkg::ST_DVS: begin
        case (div_sel)
          ddo_pkg::DV_RAD: rad   <= div_q;
          ddo_pkg::DV_ANG: ang_r <= sat_rate(diff_neg, {16'd0, div_q[63:16]});
          ddo_pkg::DV_LIN: lin_r <= sat_rate(sum_neg, div_q);
          ddo_pkg::DV_LFT: lft_r <= sat_rate(lt_neg, {16'd0, div_q[63:16]});
          default:         rgt_r <= sat_rate(rt_neg, {16'd0, div_q[63:16]});
        endcase
      end

      // Radians to binary angle: keep bits 96..64 of the full product.
      ddo_pkg::ST_H1: acc <= {33'd0, prod};
      ddo_pkg::ST_H2: acc <= acc + {1'b0, prod, 32'd0};
      ddo_pkg::ST_H3: acc <= acc + {1'b0, prod, 32'd0};
      ddo_pkg::ST_H4: acc <= acc + {prod[32:0], 64'd0};

      // CORDIC setup at the midpoint heading, left half-plane turned around.
      ddo_pkg::ST_CSET: begin
        dh   <= diff_neg ? (32'd0 - hi[31:0]) : hi[31:0];
        flip <= (mid[31:30] == 2'b01 || mid[31:30] == 2'b10);
        cx   <= $signed({2'b00, ddo_pkg::CORDIC_GAIN});
        cy   <= 34'sd0;
        cz   <= $signed({{2{ang[31]}}, ang});
      end

      // One CORDIC rotation per cycle.
      ddo_pkg::ST_CRD: begin
        if (!cz[33]) begin
          cx <= cx - sy;
          cy <= cy + sx;
          cz <= cz - $signed({2'b00, ddo_pkg::ATAN_TURNS[5'(ci)]});
        end else begin
          cx <= cx + sy;
          cy <= cy - sx;
          cz <= cz + $signed({2'b00, ddo_pkg::ATAN_TURNS[5'(ci)]});
        end
      end

      ddo_pkg::ST_FIN: begin
        if (out_go) begin
          m_tdata <= {rgt_r, lft_r, ang_r, lin_r, pose_heading, pose_y, pose_x};
        end
      end
      default: begin end
    endcase
  end

endmodule

@@ hw/rtl/ddo_checker.sv @@
// Port-level checks for the differential-drive odometry block.
// Watches only the stream ports; bound to the top level at the end of the file.
// Depends on ddo_pkg and diff_drive_odometry.
`timescale 1ns / 1ps

module ddo_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [ddo_pkg::IN_W-1:0]  s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [ddo_pkg::OUT_W-1:0] m_tdata
);

  // An item with a real interval occupies the sequencer.
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[47:32] != 16'd0 |=> !s_tready)
    else $error("input still ready after an item with nonzero interval");

  // A zero interval is dropped at once.
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[47:32] == 16'd0 |=> s_tready)
    else $error("zero-interval beat stalled the input");

  // A new result never appears straight out of idle.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a computation");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);

@@ tb/sv/diff_drive_odometry_tb.sv @@
// Self-checking testbench for the differential-drive odometry block.
// Drives tick/interval beats, predicts pose and rates in fixed point, checks each output beat.
// Depends on ddo_pkg and diff_drive_odometry.
`timescale 1ns / 1ps

module diff_drive_odometry_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 450;

  typedef struct packed {
    logic [15:0] interval;
    logic [15:0] right_ticks;
    logic [15:0] left_ticks;
  } odo_in_t;

  typedef struct {
    logic [31:0] f [7];
  } odo_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ddo_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ddo_pkg::OUT_W-1:0] m_tdata;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = ddo_pkg::CFG_TICK_SCALE;
  logic [31:0] cfg_data = '0;

  diff_drive_odometry u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the registers and pose.
  logic [31:0] scale_q;
  logic [15:0] radius_q;
  logic [15:0] sep_q;
  logic [31:0] px, py, ph;

  odo_in_t  pending_beats [$];
  odo_out_t pose_expected [$];
  int mismatches = 0;
  int results_seen = 0;
  int beats_sent = 0;
  int cycles = 0;
  bit steady = 1'b0;

  function automatic logic [63:0] mag_of(input logic signed [63:0] v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  // Shift the magnitude, then put the sign back.
  function automatic logic signed [63:0] shift_tz(input logic signed [63:0] v, input int s);
    logic [63:0] m;
    m = mag_of(v) >> s;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [31:0] sat_rate(input bit neg, input logic [63:0] m);
    if (neg) return m > 64'h80000000 ? 32'h80000000 : 32'(64'd0 - m);
    return m > 64'h7FFFFFFF ? 32'h7FFFFFFF : m[31:0];
  endfunction

  // Rotation of the gain vector to a binary angle, cos and sin in Q2.30.
  task automatic rotate(input logic [31:0] ang, output logic signed [63:0] c,
                        output logic signed [63:0] s);
    bit flip;
    logic signed [63:0] x, y, z, nx;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang ^ 32'h80000000;
    x = 64'(ddo_pkg::CORDIC_GAIN);
    y = 0;
    z = $signed({{32{ang[31]}}, ang});
    for (int i = 0; i < ddo_pkg::CORDIC_STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - shift_tz(y, i);
        y = y + shift_tz(x, i);
        z = z - $signed(64'(ddo_pkg::ATAN_TURNS[i]));
      end else begin
        nx = x + shift_tz(y, i);
        y = y - shift_tz(x, i);
        z = z + $signed(64'(ddo_pkg::ATAN_TURNS[i]));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Advance the pose for one accepted beat and queue the output it should give.
  task automatic advance_pose(input odo_in_t b);
    logic signed [63:0] lt, rt, sum, diff, ds, c, s;
    logic [63:0] dt, sep, ds_mag, rad_q32, hi, lt_m, rt_m;
    logic [127:0] prod;
    logic [31:0] dh, half;
    odo_out_t r;
    lt = 64'($signed(b.left_ticks));
    rt = 64'($signed(b.right_ticks));
    dt = 64'(b.interval);
    if (dt == 0) return;
    sep = sep_q == 0 ? 64'd1 : 64'(sep_q);
    sum = lt + rt;
    diff = rt - lt;
    ds_mag = (mag_of(sum) * 64'(scale_q) * 64'(radius_q)) >> 33;
    ds = sum < 0 ? -$signed(ds_mag) : $signed(ds_mag);
    rad_q32 = mag_of(diff) * 64'(scale_q) * 64'(radius_q) / sep;
    prod = 128'(rad_q32) * 128'(ddo_pkg::TURN_PER_RAD);
    hi = prod[127:64];
    dh = hi[31:0];
    half = hi[32:1];
    if (diff < 0) begin
      dh = 32'd0 - dh;
      half = 32'd0 - half;
    end
    rotate(ph + half, c, s);
    px = px + 32'(shift_tz(ds * c, 30));
    py = py + 32'(shift_tz(ds * s, 30));
    ph = ph + dh;
    lt_m = mag_of(lt);
    rt_m = mag_of(rt);
    r.f[0] = px;
    r.f[1] = py;
    r.f[2] = ph;
    r.f[3] = sat_rate(sum < 0, ds_mag / dt);
    r.f[4] = sat_rate(diff < 0, (rad_q32 / dt) >> 16);
    r.f[5] = sat_rate(lt < 0, (lt_m * 64'(scale_q) / dt) >> 16);
    r.f[6] = sat_rate(rt < 0, (rt_m * 64'(scale_q) / dt) >> 16);
    pose_expected.push_back(r);
  endtask

  // Driver: presents queued beats, with random gaps unless steady is set.
  always @(posedge clk) begin
    bit taken, gap;
    odo_in_t nb;
    if (!rst) begin
      taken = s_tvalid && s_tready;
      if (taken) begin
        advance_pose(odo_in_t'(s_tdata));
        beats_sent++;
      end
      if (taken || !s_tvalid) begin
        gap = !steady && ($urandom_range(99) < 26);
        if (!gap && pending_beats.size() > 0) begin
          nb = pending_beats.pop_front();
          s_tdata <= nb;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure unless steady is set, and field-by-field compare.
  always @(posedge clk) begin
    odo_out_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pose_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %h", m_tdata);
        end else begin
          e = pose_expected.pop_front();
          for (int k = 0; k < 7; k++) begin
            if (m_tdata[32*k +: 32] !== e.f[k]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("beat %0d field %0d: expected %h got %h",
                         results_seen, k, e.f[k], m_tdata[32*k +: 32]);
            end
          end
        end
      end
      m_tready <= steady || ($urandom_range(99) >= 26);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d outputs outstanding", pose_expected.size());
      $display("FAIL diff_drive_odometry");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      ddo_pkg::CFG_TICK_SCALE:   scale_q = val;
      ddo_pkg::CFG_WHEEL_RADIUS: radius_q = val[15:0];
      ddo_pkg::CFG_WHEEL_SEP:    sep_q = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] sc, input logic [15:0] rad,
                          input logic [15:0] sp);
    write_reg(ddo_pkg::CFG_TICK_SCALE, sc);
    write_reg(ddo_pkg::CFG_WHEEL_RADIUS, {16'd0, rad});
    write_reg(ddo_pkg::CFG_WHEEL_SEP, {16'd0, sp});
  endtask

  // Block until every beat is sent and answered, then let a trailing skip beat drain.
  task automatic drain();
    while (pending_beats.size() > 0 || s_tvalid || pose_expected.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_beat(input int lt, input int rt, input int dt);
    odo_in_t b;
    b.left_ticks = 16'(lt);
    b.right_ticks = 16'(rt);
    b.interval = 16'(dt);
    pending_beats.push_back(b);
  endtask

  // Mostly moderate motion over short intervals, with full-range ticks now and then.
  task automatic queue_random(input int n);
    int lt, rt, dt, sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        lt = $urandom();
        rt = $urandom();
      end else begin
        lt = $signed(11'($urandom()));
        rt = (sel < 40) ? lt : ((sel < 50) ? -lt : $signed(11'($urandom())));
      end
      case ($urandom_range(9))
        0: dt = 0;
        1: dt = $urandom_range(65535);
        2: dt = 1;
        default: dt = $urandom_range(1, 300);
      endcase
      queue_beat(lt, rt, dt);
    end
  endtask

  initial begin
    scale_q = ddo_pkg::RST_TICK_SCALE;
    radius_q = ddo_pkg::RST_WHEEL_RADIUS;
    sep_q = ddo_pkg::RST_WHEEL_SEP;
    px = '0;
    py = '0;
    ph = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed beats on reset settings: extremes, skips, straight, spin.
    queue_beat(0, 0, 1);
    queue_beat(100, 100, 10);
    queue_beat(-32768, -32768, 1);
    queue_beat(32767, 32767, 65535);
    queue_beat(5, 7, 0);
    queue_beat(-32768, 32767, 1);
    queue_beat(32767, -32768, 3);
    queue_beat(-200, 200, 50);
    queue_beat(0, 32767, 65535);
    queue_beat(-1, 0, 2);
    queue_beat(1, -1, 0);
    queue_beat(-32768, 0, 1);
    drain();

    // Largest scale and radius, smallest separation: many turns per beat.
    set_regs(32'hFFFFFFFF, 16'hFFFF, 16'd1);
    queue_beat(-32768, 32767, 1);
    queue_beat(32767, -32768, 1);
    queue_beat(-32768, -32768, 1);
    queue_beat(1, 3, 65535);
    queue_random(150);
    drain();

    // Smallest scale and radius against the widest separation, no idling.
    steady = 1'b1;
    set_regs(32'd1, 16'd1, 16'hFFFF);
    queue_random(150);
    drain();
    steady = 1'b0;

    // Zero separation and zero radius.
    set_regs(32'd6588397, 16'd0, 16'd0);
    queue_random(40);
    drain();
    write_reg(ddo_pkg::CFG_WHEEL_RADIUS, 32'd2163);
    queue_random(80);
    drain();

    // Back to reset values, then random settings.
    set_regs(ddo_pkg::RST_TICK_SCALE, ddo_pkg::RST_WHEEL_RADIUS, ddo_pkg::RST_WHEEL_SEP);
    queue_random(200);
    drain();
    for (int p = 0; p < 4; p++) begin
      set_regs($urandom(), 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      queue_random(80);
      drain();
    end

    $display("sent %0d input beats over ten register settings, checked %0d output beats",
             beats_sent, results_seen);
    if (mismatches == 0 && pose_expected.size() == 0) begin
      $display("PASS diff_drive_odometry");
    end else begin
      $display("%0d mismatched fields, %0d outputs missing", mismatches, pose_expected.size());
      $display("FAIL diff_drive_odometry");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ddo_pkg.sv
hw/rtl/diff_drive_odometry.sv
hw/rtl/ddo_checker.sv
tb/sv/diff_drive_odometry_tb.sv
